FILE: hdl/costmap_goal_snap_search_defines.svh
// ----------------------------------------------------------------------------
// costmap_goal_snap_search_defines
// Assertion macros used by the goal snap search controller.
// ----------------------------------------------------------------------------
`ifndef COSTMAP_GOAL_SNAP_SEARCH_DEFINES_SVH
`define COSTMAP_GOAL_SNAP_SEARCH_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CSM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CSM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// Types and constants of the costmap goal snap search.
// ----------------------------------------------------------------------------
package csm_pkg;

   localparam int STORE_AW    = 16;
   localparam int STORE_DEPTH = 65536;
   localparam int SIZE_W      = 31;
   localparam int COORD_W     = 32;
   localparam int COST_W      = 8;

   localparam logic [15:0] DIAG_Q16   = 16'd46334;
   localparam logic [47:0] ROUND_HALF = 48'd32768;
   localparam logic [7:0]  NO_COST    = 8'hFF;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] ST_KEPT    = 2'd0;
   localparam logic [1:0] ST_SNAPPED = 2'd1;
   localparam logic [1:0] ST_FAILED  = 2'd2;

   localparam logic [2:0] REG_MAP_WIDTH  = 3'd0;
   localparam logic [2:0] REG_MAP_HEIGHT = 3'd1;
   localparam logic [2:0] REG_ORIGIN_X   = 3'd2;
   localparam logic [2:0] REG_ORIGIN_Y   = 3'd3;
   localparam logic [2:0] REG_CELL_SIZE  = 3'd4;
   localparam logic [2:0] REG_THRESHOLD  = 3'd5;
   localparam logic [2:0] REG_MAX_RADIUS = 3'd6;
   localparam logic [2:0] REG_STEP       = 3'd7;

   localparam logic [2:0] DIR_E  = 3'd0;
   localparam logic [2:0] DIR_NE = 3'd1;
   localparam logic [2:0] DIR_N  = 3'd2;
   localparam logic [2:0] DIR_NW = 3'd3;
   localparam logic [2:0] DIR_W  = 3'd4;
   localparam logic [2:0] DIR_SW = 3'd5;
   localparam logic [2:0] DIR_S  = 3'd6;
   localparam logic [2:0] DIR_SE = 3'd7;

   typedef struct packed {
      logic       accept_write;
      logic       accept_query;
      logic       check;
      logic       index;
      logic       read;
      logic       save_goal;
      logic       ring_clear;
      logic       ring_step;
      logic       diag;
      logic       cand;
      logic       dir_inc;
      logic       finish;
      logic [1:0] fin_status;
   } ctl_cmd_type;

   typedef struct packed {
      logic bad;
      logic div_done;
      logic free;
      logic dir_last;
      logic r_over;
   } ctl_stat_type;

endpackage

FILE: hdl/csm_div.sv
// ----------------------------------------------------------------------------
// csm_div
// Restoring divider, one quotient bit per cycle, for a dividend known to
// be below divisor * 2**QB.
// ----------------------------------------------------------------------------
module csm_div import csm_pkg::*; #(
   parameter int QB = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SIZE_W+QB-1:0] dividend,
   input  logic [SIZE_W-1:0]    divisor,
   output logic [QB-1:0]        quotient,
   output logic                 done
);
   localparam int CW = SIZE_W + QB;
   localparam int NW = $clog2(QB + 1);

   logic [CW-1:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QB-1:0] q_ff, q_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          ge;

   assign ge = rem_ff >= dsh_ff;

   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (start) begin
         rem_in = dividend;
         dsh_in = CW'(divisor) << (QB - 1);
         cnt_in = NW'(QB - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? rem_ff - dsh_ff : rem_ff;
         q_in   = {q_ff[QB-2:0], ge};
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            run_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   assign quotient = q_ff;
   assign done     = !run_ff;

endmodule

FILE: hdl/csm_dp.sv
// ----------------------------------------------------------------------------
// csm_dp
// Datapath: configuration, cost memory, cell lookup, ring and candidate
// arithmetic and the result registers.
// ----------------------------------------------------------------------------
module csm_dp import csm_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int QB         = 9
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_cmd_type               ctl,
   output ctl_stat_type              stat,
   input  logic [15:0]               req_cell_index,
   input  logic [7:0]                req_cell_cost,
   input  logic signed [31:0]        req_goal_x,
   input  logic signed [31:0]        req_goal_y,
   input  logic                      csr_wr_en,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_wdata,
   output logic [1:0]                rsp_status,
   output logic signed [31:0]        rsp_out_x,
   output logic signed [31:0]        rsp_out_y,
   output logic [7:0]                rsp_goal_cost
);
   localparam int CW = SIZE_W + QB;
   localparam int NW = CW + 1;
   localparam int IW = 2 * QB;

   logic [8:0]            map_width_ff, map_height_ff;
   logic signed [31:0]    origin_x_ff, origin_y_ff;
   logic [SIZE_W-1:0]     cell_size_ff, max_radius_ff, step_ff;
   logic [7:0]            thresh_ff;
   logic                  map_present_ff;

   logic [7:0]            mem [STORE_DEPTH];
   logic [7:0]            rd_ff;

   logic signed [31:0]    goal_x_ff, goal_y_ff;
   logic signed [33:0]    cand_x_ff, cand_y_ff;
   logic [31:0]           r_ff, dg_ff, r_new;
   logic [2:0]            dir_ff;
   logic                  bad_ff;
   logic [IW-1:0]         idx_ff;
   logic [7:0]            goal_cost_ff;
   logic [1:0]            status_ff;
   logic signed [31:0]    out_x_ff, out_y_ff;

   logic [QB-1:0]         w_lim, h_lim, qx, qy;
   logic                  done_x, done_y;
   logic signed [NW-1:0]  num_x, num_y;
   logic [NW-1:0]         lim;
   logic                  in_x, in_y, bad_now, out_cell;
   logic [7:0]            cost;
   logic [47:0]           diag_prod;
   logic [31:0]           off;
   logic                  dxp, dxn, dyp, dyn, diag_dir;
   logic signed [33:0]    offe;

   assign w_lim = (QB'(map_width_ff) < QB'(MAX_WIDTH)) ? QB'(map_width_ff) : QB'(MAX_WIDTH);
   assign h_lim = (QB'(map_height_ff) < QB'(MAX_HEIGHT)) ? QB'(map_height_ff)
                                                         : QB'(MAX_HEIGHT);

   // A point maps to a cell only when both offsets are non-negative and the
   // quotient fits in QB bits; everything else is off the map.
   assign in_x  = cand_x_ff == {{2{cand_x_ff[31]}}, cand_x_ff[31:0]};
   assign in_y  = cand_y_ff == {{2{cand_y_ff[31]}}, cand_y_ff[31:0]};
   assign num_x = NW'(cand_x_ff) - NW'(origin_x_ff);
   assign num_y = NW'(cand_y_ff) - NW'(origin_y_ff);
   assign lim   = {1'b0, cell_size_ff, {QB{1'b0}}};
   assign bad_now = !map_present_ff || (cell_size_ff == '0) || !in_x || !in_y
                    || num_x[NW-1] || num_y[NW-1]
                    || ($unsigned(num_x) >= lim) || ($unsigned(num_y) >= lim);

   csm_div #(.QB(QB)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.check && !bad_now),
      .dividend (num_x[CW-1:0]),
      .divisor  (cell_size_ff),
      .quotient (qx),
      .done     (done_x)
   );

   csm_div #(.QB(QB)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.check && !bad_now),
      .dividend (num_y[CW-1:0]),
      .divisor  (cell_size_ff),
      .quotient (qy),
      .done     (done_y)
   );

   assign out_cell  = (qx >= w_lim) || (qy >= h_lim);
   assign cost      = bad_ff ? NO_COST : rd_ff;
   assign r_new     = r_ff + 32'(step_ff);
   assign diag_prod = 48'(r_ff) * 48'(DIAG_Q16) + ROUND_HALF;

   always_comb begin
      dxp = 1'b0;
      dxn = 1'b0;
      dyp = 1'b0;
      dyn = 1'b0;
      diag_dir = 1'b0;
      unique case (dir_ff)
         DIR_E:  dxp = 1'b1;
         DIR_NE: begin dxp = 1'b1; dyp = 1'b1; diag_dir = 1'b1; end
         DIR_N:  dyp = 1'b1;
         DIR_NW: begin dxn = 1'b1; dyp = 1'b1; diag_dir = 1'b1; end
         DIR_W:  dxn = 1'b1;
         DIR_SW: begin dxn = 1'b1; dyn = 1'b1; diag_dir = 1'b1; end
         DIR_S:  dyn = 1'b1;
         DIR_SE: begin dxp = 1'b1; dyn = 1'b1; diag_dir = 1'b1; end
         default: ;
      endcase
   end

   assign off  = diag_dir ? dg_ff : r_ff;
   assign offe = signed'({2'b00, off});

   assign stat.bad      = bad_now;
   assign stat.div_done = done_x && done_y;
   assign stat.free     = cost < thresh_ff;
   assign stat.dir_last = dir_ff == DIR_SE;
   assign stat.r_over   = r_new > {1'b0, max_radius_ff};

   always_ff @(posedge clock) begin
      if (ctl.accept_write) begin
         mem[req_cell_index] <= req_cell_cost;
      end
      if (ctl.read) begin
         rd_ff <= mem[idx_ff[STORE_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff   <= 9'd256;
         map_height_ff  <= 9'd256;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         cell_size_ff   <= 31'd3277;
         thresh_ff      <= 8'd253;
         max_radius_ff  <= 31'd65536;
         step_ff        <= 31'd6554;
         map_present_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_MAP_WIDTH:  map_width_ff  <= csr_wdata[8:0];
               REG_MAP_HEIGHT: map_height_ff <= csr_wdata[8:0];
               REG_ORIGIN_X:   origin_x_ff   <= signed'(csr_wdata);
               REG_ORIGIN_Y:   origin_y_ff   <= signed'(csr_wdata);
               REG_CELL_SIZE:  cell_size_ff  <= csr_wdata[30:0];
               REG_THRESHOLD:  thresh_ff     <= csr_wdata[7:0];
               REG_MAX_RADIUS: max_radius_ff <= csr_wdata[30:0];
               REG_STEP:       step_ff       <= csr_wdata[30:0];
               default: ;
            endcase
         end
         if (ctl.accept_write) begin
            map_present_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept_query) begin
         goal_x_ff <= req_goal_x;
         goal_y_ff <= req_goal_y;
         cand_x_ff <= 34'(req_goal_x);
         cand_y_ff <= 34'(req_goal_y);
      end
      if (ctl.check) begin
         bad_ff <= bad_now;
      end
      if (ctl.index) begin
         idx_ff <= IW'(qy) * IW'(w_lim) + IW'(qx);
         bad_ff <= bad_ff | out_cell;
      end
      if (ctl.read) begin
         bad_ff <= bad_ff | ((idx_ff >> STORE_AW) != '0);
      end
      if (ctl.save_goal) begin
         goal_cost_ff <= cost;
      end
      if (ctl.ring_clear) begin
         r_ff <= '0;
      end
      if (ctl.ring_step) begin
         r_ff   <= r_new;
         dir_ff <= DIR_E;
      end
      if (ctl.dir_inc) begin
         dir_ff <= dir_ff + 3'd1;
      end
      if (ctl.diag) begin
         dg_ff <= diag_prod[47:16];
      end
      if (ctl.cand) begin
         cand_x_ff <= dxp ? 34'(goal_x_ff) + offe
                    : dxn ? 34'(goal_x_ff) - offe : 34'(goal_x_ff);
         cand_y_ff <= dyp ? 34'(goal_y_ff) + offe
                    : dyn ? 34'(goal_y_ff) - offe : 34'(goal_y_ff);
      end
      if (ctl.finish) begin
         status_ff <= ctl.fin_status;
         if (ctl.fin_status == ST_SNAPPED) begin
            out_x_ff <= cand_x_ff[31:0];
            out_y_ff <= cand_y_ff[31:0];
         end else begin
            out_x_ff <= goal_x_ff;
            out_y_ff <= goal_y_ff;
         end
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_goal_cost = goal_cost_ff;

endmodule

FILE: hdl/csm_ctrl.sv
// ----------------------------------------------------------------------------
// csm_ctrl
// Sequencer of the goal lookup and the ring search.
// ----------------------------------------------------------------------------
`include "costmap_goal_snap_search_defines.svh"

module csm_ctrl import csm_pkg::*; #(
   parameter int MAX_RINGS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         req_cmd,
   output logic         busy,
   output logic         rsp_valid,
   output ctl_cmd_type  ctl,
   input  ctl_stat_type stat
);
   localparam int KW = $clog2(MAX_RINGS + 1);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_PREP = 9'b000000010,
      S_DIV  = 9'b000000100,
      S_MUL  = 9'b000001000,
      S_ADDR = 9'b000010000,
      S_EVAL = 9'b000100000,
      S_RING = 9'b001000000,
      S_DIAG = 9'b010000000,
      S_CAND = 9'b100000000
   } state_type;

   state_type     state_ff, state_in;
   logic          probe_ff, probe_in;
   logic [KW-1:0] k_ff, k_in;
   logic          rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      probe_in = probe_ff;
      k_in     = k_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_WRITE) begin
                  ctl.accept_write = 1'b1;
               end else begin
                  ctl.accept_query = 1'b1;
                  probe_in = 1'b0;
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            ctl.check = 1'b1;
            state_in  = stat.bad ? S_EVAL : S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            ctl.index = 1'b1;
            state_in  = S_ADDR;
         end
         S_ADDR: begin
            ctl.read = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (!probe_ff) begin
               ctl.save_goal = 1'b1;
               if (stat.free) begin
                  ctl.finish     = 1'b1;
                  ctl.fin_status = ST_KEPT;
                  state_in       = S_IDLE;
               end else begin
                  ctl.ring_clear = 1'b1;
                  probe_in       = 1'b1;
                  k_in           = '0;
                  state_in       = S_RING;
               end
            end else if (stat.free) begin
               ctl.finish     = 1'b1;
               ctl.fin_status = ST_SNAPPED;
               state_in       = S_IDLE;
            end else if (stat.dir_last) begin
               state_in = S_RING;
            end else begin
               ctl.dir_inc = 1'b1;
               state_in    = S_CAND;
            end
         end
         S_RING: begin
            if (k_ff == KW'(MAX_RINGS) || stat.r_over) begin
               ctl.finish     = 1'b1;
               ctl.fin_status = ST_FAILED;
               state_in       = S_IDLE;
            end else begin
               ctl.ring_step = 1'b1;
               k_in          = k_ff + 1'b1;
               state_in      = S_DIAG;
            end
         end
         S_DIAG: begin
            ctl.diag = 1'b1;
            state_in = S_CAND;
         end
         S_CAND: begin
            ctl.cand = 1'b1;
            state_in = S_PREP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         probe_ff     <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         probe_ff     <= probe_in;
         k_ff         <= k_in;
         rsp_valid_ff <= ctl.finish;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   `CSM_ASSERT_NEXT(a_strobe_single, rsp_valid_ff, !rsp_valid_ff, "result strobe held")
   `CSM_ASSERT_NOW(a_strobe_idle, rsp_valid_ff, state_ff == S_IDLE, "strobe while busy")
   `CSM_ASSERT_NEXT(a_query_busy, start && !busy && req_cmd == CMD_QUERY, busy, "query lost")
   `CSM_ASSERT_NOW(a_ring_cap, state_ff == S_DIAG, k_ff != '0 && k_ff <= KW'(MAX_RINGS), "ring")

endmodule

FILE: hdl/costmap_goal_snap_search.sv
// ----------------------------------------------------------------------------
// costmap_goal_snap_search
// Byte costmap with goal snapping to the nearest free point by ring search.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. A write item
// (req_cmd low) stores req_cell_cost at req_cell_index, marks
// the map present and produces no result. A query item (req_cmd high)
// looks up the goal cell and, if it is not free, probes rings of eight points
// around it until a free point is found or the search runs out.
// Each lookup of a point that passes the range check runs the bit-serial
// dividers that turn both coordinates into a cell in parallel (QB is 9 by
// default), then the registered memory read. A query costs one lookup for
// the goal and one per probed point, plus the ring steps and a closing step;
// busy stays high meanwhile. The result appears on the rsp_ ports with
// rsp_valid high for exactly one cycle; the receiver cannot stall it.
// Configuration is written through csr_wr_en, csr_index and csr_wdata; the
// user must do so while no query is running; the block does not enforce it.
// Reset (synchronous) restores the register defaults and marks the map
// absent; the cost memory keeps its contents and is not cleared.
// ----------------------------------------------------------------------------
module costmap_goal_snap_search import csm_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_RINGS  = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_cmd,
   input  logic [15:0]        req_cell_index,
   input  logic [7:0]         req_cell_cost,
   input  logic signed [31:0] req_goal_x,
   input  logic signed [31:0] req_goal_y,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic [7:0]         rsp_goal_cost,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   localparam int DIM_W = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1))
                          ? $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
   localparam int QB    = (DIM_W > 9) ? DIM_W : 9;

   ctl_cmd_type  ctl;
   ctl_stat_type stat;

   csm_ctrl #(.MAX_RINGS(MAX_RINGS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl),
      .stat      (stat)
   );

   csm_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .QB(QB)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .stat           (stat),
      .req_cell_index (req_cell_index),
      .req_cell_cost  (req_cell_cost),
      .req_goal_x     (req_goal_x),
      .req_goal_y     (req_goal_y),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_status     (rsp_status),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_goal_cost  (rsp_goal_cost)
   );

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the costmap goal snap search. Every accepted word
// runs through a predictor that keeps its own copy of the cost grid and the
// registers. Each result word is compared field by field with the oldest
// expected word. The run steps through a set of fixed and random register
// settings and drives a mix of cell writes and goal queries.
// ----------------------------------------------------------------------------
module tb_top import csm_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  MAXW = 256;
   localparam int  MAXH = 256;
   localparam int  RINGS = 64;
   localparam int  FILL = 64;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] x;
      logic [31:0] y;
      logic [7:0]  cost;
   } snap_word_type;

   class snap_scoreboard;
      logic [7:0]    grid[STORE_DEPTH];
      bit            written[STORE_DEPTH];
      bit            stray;
      bit            have_map;
      longint        width, height, cell_sz, thresh, radius, step, org_x, org_y;
      snap_word_type pending[$];
      int            mismatches, results, kept, snapped, failed;

      function void clear();
         have_map = 0;
         width = 256; height = 256; org_x = 0; org_y = 0;
         cell_sz = 3277; thresh = 253; radius = 65536; step = 6554;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            REG_MAP_WIDTH:  width = v[8:0];
            REG_MAP_HEIGHT: height = v[8:0];
            REG_ORIGIN_X:   org_x = longint'($signed(v));
            REG_ORIGIN_Y:   org_y = longint'($signed(v));
            REG_CELL_SIZE:  cell_sz = v[30:0];
            REG_THRESHOLD:  thresh = v[7:0];
            REG_MAX_RADIUS: radius = v[30:0];
            REG_STEP:       step = v[30:0];
            default: ;
         endcase
      endfunction

      function longint floor_div(longint n, longint d);
         longint q;
         q = n / d;
         if ((n % d) != 0 && n < 0) q = q - 1;
         return q;
      endfunction

      function logic [7:0] cost_at(longint wx, longint wy);
         longint gx, gy, w, h, idx;
         if (!have_map || cell_sz == 0) return NO_COST;
         if (wx < -64'sd2147483648 || wx > 64'sd2147483647 ||
             wy < -64'sd2147483648 || wy > 64'sd2147483647) return NO_COST;
         w = (width < MAXW) ? width : MAXW;
         h = (height < MAXH) ? height : MAXH;
         gx = floor_div(wx - org_x, cell_sz);
         gy = floor_div(wy - org_y, cell_sz);
         if (gx < 0 || gy < 0 || gx >= w || gy >= h) return NO_COST;
         idx = gy * w + gx;
         if (idx >= STORE_DEPTH) return NO_COST;
         // A never-written entry has no defined cost; such queries are not sent.
         if (!written[idx]) stray = 1;
         return grid[idx];
      endfunction

      function snap_word_type predict(logic [31:0] gx32, logic [31:0] gy32);
         snap_word_type e;
         longint gx, gy, off, tx, ty, ax, dg;
         longint unsigned r;
         int dx[8], dy[8];
         dx = '{1, 1, 0, -1, -1, -1, 0, 1};
         dy = '{0, 1, 1, 1, 0, -1, -1, -1};
         gx = longint'($signed(gx32));
         gy = longint'($signed(gy32));
         e.cost = cost_at(gx, gy);
         e.status = ST_FAILED;
         e.x = gx32;
         e.y = gy32;
         if (e.cost < thresh) begin
            e.status = ST_KEPT;
         end else begin
            for (int k = 1; k <= RINGS && e.status == ST_FAILED; k++) begin
               r = longint'(k) * step;
               if (r > radius) break;
               ax = r;
               dg = (r * 46334 + 32768) >> 16;
               for (int d = 0; d < 8; d++) begin
                  off = (dx[d] != 0 && dy[d] != 0) ? dg : ax;
                  tx = gx + dx[d] * off;
                  ty = gy + dy[d] * off;
                  if (cost_at(tx, ty) < thresh) begin
                     e.status = ST_SNAPPED;
                     e.x = tx[31:0];
                     e.y = ty[31:0];
                     break;
                  end
               end
            end
         end
         return e;
      endfunction

      // True when the query reads only entries that have been written.
      function bit safe_query(logic [31:0] gx32, logic [31:0] gy32);
         snap_word_type e;
         stray = 0;
         e = predict(gx32, gy32);
         return !stray;
      endfunction

      function void note(logic cmd, logic [15:0] idx, logic [7:0] c,
                         logic [31:0] gx32, logic [31:0] gy32);
         if (cmd == CMD_WRITE) begin
            grid[idx] = c;
            written[idx] = 1;
            have_map = 1;
            return;
         end
         pending.push_back(predict(gx32, gy32));
      endfunction

      function void check(logic [1:0] st, logic [31:0] x, logic [31:0] y,
                          logic [7:0] c);
         snap_word_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: status=%0d x=%h y=%h cost=%0d",
                        st, x, y, c);
            return;
         end
         e = pending.pop_front();
         results++;
         if (st !== e.status || x !== e.x || y !== e.y || c !== e.cost) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected status=%0d x=%h y=%h cost=%0d, %s",
                        e.status, e.x, e.y, e.cost,
                        $sformatf("got status=%0d x=%h y=%h cost=%0d", st, x, y, c));
         end
         if (e.status == ST_KEPT) kept++;
         else if (e.status == ST_SNAPPED) snapped++;
         else failed++;
      endfunction
   endclass

   logic               clock, reset, start, busy;
   logic               req_cmd;
   logic [15:0]        req_cell_index;
   logic [7:0]         req_cell_cost;
   logic signed [31:0] req_goal_x, req_goal_y;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_out_x, rsp_out_y;
   logic [7:0]         rsp_goal_cost;
   logic               csr_wr_en;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;

   snap_scoreboard sb;
   longint cycles;
   int     words_in;

   costmap_goal_snap_search #(.MAX_WIDTH(MAXW), .MAX_HEIGHT(MAXH), .MAX_RINGS(RINGS)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_cell_index(req_cell_index),
      .req_cell_cost(req_cell_cost), .req_goal_x(req_goal_x),
      .req_goal_y(req_goal_y), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_goal_cost(rsp_goal_cost), .csr_wr_en(csr_wr_en),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid) sb.check(rsp_status, rsp_out_x, rsp_out_y, rsp_goal_cost);

   function int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Holds start high until the word is taken; start drops for a gap or in drain.
   task automatic send(int gap, logic cmd, logic [15:0] idx, logic [7:0] c,
                       logic [31:0] gx, logic [31:0] gy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_cell_index <= idx;
      req_cell_cost <= c;
      req_goal_x <= gx;
      req_goal_y <= gy;
      do @(posedge clock); while (busy);
      sb.note(cmd, idx, c, gx, gy);
      words_in++;
   endtask

   task automatic try_query(int gap, logic [31:0] gx, logic [31:0] gy);
      if (sb.safe_query(gx, gy)) send(gap, CMD_QUERY, 16'd0, 8'd0, gx, gy);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_regs(logic [31:0] v[8]);
      drain();
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= v[i];
         @(posedge clock);
         sb.set_reg(i[2:0], v[i]);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function logic [7:0] rand_cost();
      if ($urandom_range(0, 1)) return 8'($urandom_range(253, 255));
      return 8'($urandom_range(0, 255));
   endfunction

   // Goal mostly lands inside the active grid so that searches have real neighbors.
   // A query that would read a never-written entry is replaced by a cell write.
   task automatic random_word();
      longint      w, h, cx, cy;
      logic [31:0] qx, qy;
      bit          found;
      found = 0;
      qx = '0;
      qy = '0;
      if ($urandom_range(0, 99) >= 40) begin
         for (int t = 0; t < 8 && !found; t++) begin
            if ($urandom_range(0, 99) < 80 && sb.cell_sz != 0) begin
               w = (sb.width < MAXW) ? sb.width : MAXW;
               h = (sb.height < MAXH) ? sb.height : MAXH;
               if (w < 1) w = 1;
               if (h < 1) h = 1;
               cx = sb.org_x + longint'($urandom_range(0, 32'(w - 1))) * sb.cell_sz
                    + longint'($urandom_range(0, 32'(sb.cell_sz - 1)));
               cy = sb.org_y + longint'($urandom_range(0, 32'(h - 1))) * sb.cell_sz
                    + longint'($urandom_range(0, 32'(sb.cell_sz - 1)));
               qx = cx[31:0];
               qy = cy[31:0];
            end else begin
               qx = $urandom;
               qy = $urandom;
            end
            found = sb.safe_query(qx, qy);
         end
      end
      if (found) begin
         send(pick_gap(), CMD_QUERY, 16'($urandom), 8'($urandom), qx, qy);
      end else begin
         send(pick_gap(), CMD_WRITE, 16'($urandom_range(0, FILL - 1)), rand_cost(),
              $urandom, $urandom);
      end
   endtask

   initial begin
      logic [31:0] cfg[8];
      sb = new();
      sb.clear();
      cycles = 0;
      words_in = 0;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_WRITE;
      req_cell_index = '0;
      req_cell_cost = '0;
      req_goal_x = '0;
      req_goal_y = '0;
      csr_wr_en = 1'b0;
      csr_index = REG_MAP_WIDTH;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // No map yet: every lookup costs the maximum.
      send(0, CMD_QUERY, 16'd0, 8'd0, 32'd0, 32'd0);
      send(2, CMD_QUERY, 16'd0, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF);

      // The first entries cover every cell of the small maps used later.
      for (int i = 0; i < FILL; i++)
         send(0, CMD_WRITE, 16'(i), rand_cost(), $urandom, $urandom);

      send(0, CMD_WRITE, 16'd0, 8'd0, 32'd0, 32'd0);
      try_query(0, 32'd0, 32'd0);
      send(1, CMD_WRITE, 16'd0, 8'd255, 32'd0, 32'd0);
      send(0, CMD_WRITE, 16'd2, 8'd0, 32'd0, 32'd0);
      send(0, CMD_WRITE, 16'd257, 8'd10, 32'd0, 32'd0);
      try_query(0, 32'd100, 32'd100);
      try_query(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      try_query(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      try_query(0, 32'h8000_0000, 32'h8000_0000);
      send(0, CMD_WRITE, 16'hFFFF, 8'd252, 32'd0, 32'd0);
      try_query(0, 32'd838000, 32'd838000);

      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: cfg = '{256, 256, 0, 0, 3277, 253, 65536, 6554};
            1: cfg = '{1, 1, 32'hFFFF_0000, 32'hFFFF_0000, 65536, 128, 131072, 65536};
            2: cfg = '{32'hFFFF_FFFF, 511, 32'h8000_0000, 32'h7FFF_FFFF, 1, 255,
                       32'h7FFF_FFFF, 32'hFFFF_FFFF};
            3: cfg = '{16, 16, 0, 0, 0, 253, 65536, 6554};
            4: cfg = '{8, 8, 0, 0, 65536, 0, 65536, 65536};
            5: cfg = '{8, 8, 0, 0, 65536, 200, 65536, 0};
            6: cfg = '{0, 300, 0, 0, 65536, 200, 262144, 65536};
            7: cfg = '{256, 256, 0, 0, 32'h7FFF_FFFF, 254, 0, 1};
            default: begin
               cfg[0] = ($urandom & ~32'h1FF) | $urandom_range(1, 8);
               cfg[1] = ($urandom & ~32'h1FF) | $urandom_range(1, 8);
               cfg[2] = $urandom;
               cfg[3] = $urandom;
               cfg[4] = $urandom_range(1, 200000);
               cfg[5] = $urandom_range(0, 255);
               cfg[6] = $urandom_range(0, 2000000);
               cfg[7] = $urandom_range(1, 300000);
            end
         endcase
         write_regs(cfg);
         repeat (6) random_word();
      end

      drain();
      $display("Ran %0d words over 12 register settings plus defaults.", words_in);
      $display("Checked %0d results: %0d kept, %0d snapped, %0d failed.",
               sb.results, sb.kept, sb.snapped, sb.failed);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/csm_pkg.sv
hdl/csm_div.sv
hdl/csm_dp.sv
hdl/csm_ctrl.sv
hdl/costmap_goal_snap_search.sv
tb/sv/tb_top.sv
